// ===== src/dbpc_pkg.sv =====
// shared types and constants for the two-button debounce period controller
package dbpc_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned PERIOD_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0]   TICK_TOP           = '1;
  localparam logic [TICK_W-1:0]   DEBOUNCE_RESET     = 16'd100;
  localparam logic [TICK_W-1:0]   LONG_PRESS_RESET   = 16'd2000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX_RESET   = 4'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET       = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_PERIOD_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_MINUS_DB   = 3'd1,
    PH_MINUS_ACT  = 3'd2,
    PH_MINUS_HELD = 3'd3,
    PH_RELEASE_DB = 3'd4,
    PH_PLUS_DB    = 3'd5,
    PH_PLUS_ACT   = 3'd6,
    PH_PLUS_HELD  = 3'd7
  } phase_t;

  typedef struct packed {
    logic minus_level;
    logic plus_level;
  } in_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                audio_on;
    logic [2:0]          phase;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]   debounce_ticks;
    logic [TICK_W-1:0]   long_press_ticks;
    logic [PERIOD_W-1:0] period_max;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [TICK_W-1:0]   elapsed;
    logic [PERIOD_W-1:0] period;
    logic                audio;
  } ctrl_state_t;

endpackage

// ===== src/dbpc_cfg.sv =====
// configuration register file
module dbpc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpc_pkg::TICK_W-1:0]     cfg_data,
  output dbpc_pkg::cfg_t                  cfg_o
);
  import dbpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   cfg_nxt.debounce_ticks   = cfg_data;
        CFG_LONG_PRESS: cfg_nxt.long_press_ticks = cfg_data;
        CFG_PERIOD_MAX: cfg_nxt.period_max       = cfg_data[PERIOD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= LONG_PRESS_RESET;
      cfg_r.period_max       <= PERIOD_MAX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/dbpc_step.sv =====
// next-state logic for one tick of the button controller
module dbpc_step (
  input  dbpc_pkg::in_item_t     item_i,
  input  dbpc_pkg::cfg_t         cfg_i,
  input  dbpc_pkg::ctrl_state_t  state_i,
  output dbpc_pkg::ctrl_state_t  state_o
);
  import dbpc_pkg::*;

  logic                minus_down;
  logic                plus_down;
  logic                clear;
  logic                db_done;
  logic                lp_done;
  logic [PERIOD_W-1:0] mx;

  assign minus_down = ~item_i.minus_level;
  assign plus_down  = ~item_i.plus_level;
  assign db_done    = state_i.elapsed >= cfg_i.debounce_ticks;
  assign lp_done    = state_i.elapsed >= cfg_i.long_press_ticks;
  assign mx = (cfg_i.period_max == '0) ? PERIOD_W'(1) : cfg_i.period_max;

  always_comb begin
    state_o = state_i;
    clear   = 1'b0;
    unique case (state_i.phase)
      PH_IDLE: begin
        if (minus_down) begin
          clear         = 1'b1;
          state_o.phase = PH_MINUS_DB;
        end else if (plus_down) begin
          clear         = 1'b1;
          state_o.phase = PH_PLUS_DB;
        end
      end
      PH_MINUS_DB: begin
        if (db_done) state_o.phase = minus_down ? PH_MINUS_ACT : PH_IDLE;
      end
      PH_MINUS_ACT: begin
        state_o.period = (state_i.period >= mx) ? PERIOD_W'(1)
                                                : state_i.period + PERIOD_W'(1);
        state_o.phase  = PH_MINUS_HELD;
      end
      PH_MINUS_HELD: begin
        if (lp_done) begin
          state_o.audio = 1'b0;
          clear         = 1'b1;
        end
        if (!minus_down) begin
          state_o.phase = PH_RELEASE_DB;
          clear         = 1'b1;
        end
      end
      PH_RELEASE_DB: begin
        if (db_done) state_o.phase = PH_IDLE;
      end
      PH_PLUS_DB: begin
        if (db_done) state_o.phase = plus_down ? PH_PLUS_ACT : PH_IDLE;
      end
      PH_PLUS_ACT: begin
        state_o.period = (state_i.period <= PERIOD_W'(1) || state_i.period > mx)
                         ? mx : state_i.period - PERIOD_W'(1);
        state_o.phase  = PH_PLUS_HELD;
      end
      PH_PLUS_HELD: begin
        if (lp_done) begin
          state_o.audio = 1'b1;
          clear         = 1'b1;
        end
        if (!plus_down) begin
          state_o.phase = PH_RELEASE_DB;
          clear         = 1'b1;
        end
      end
    endcase

    if (clear) begin
      state_o.elapsed = '0;
    end else if (state_i.elapsed != TICK_TOP) begin
      state_o.elapsed = state_i.elapsed + TICK_W'(1);
    end
  end

endmodule

// ===== src/two_button_debounce_period_control.sv =====
// top level: input register, controller state, result register
// an accepted item goes to the input register, and its result to the result register
// throughput: one item per cycle while out_stall does not hold a full result register
// input and result registers hold the data; out_stall still reaches in_stall combinationally
// reset: synchronous active low; period 1, audio on, idle, counter 0,
// registers back to 100, 2000 and 10
module two_button_debounce_period_control (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dbpc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dbpc_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbpc_pkg::TICK_W-1:0]     cfg_data
);
  import dbpc_pkg::*;

  cfg_t        cfg;
  in_item_t    in_item_r;
  logic        in_valid_r;
  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  out_item_t   out_item_r;
  logic        out_valid_r;
  logic        out_free;
  logic        advance;

  dbpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  dbpc_step u_step (
    .item_i  (in_item_r),
    .cfg_i   (cfg),
    .state_i (state_r),
    .state_o (state_nxt)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_IDLE;
      state_r.elapsed <= '0;
      state_r.period  <= PERIOD_RESET;
      state_r.audio   <= 1'b1;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.period   <= state_nxt.period;
      out_item_r.audio_on <= state_nxt.audio;
      out_item_r.phase    <= state_nxt.phase;
    end
  end

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.period != '0)
    else $error("result period is zero");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_item_r.phase == state_r.phase &&
                 out_item_r.period == state_r.period &&
                 out_item_r.audio_on == state_r.audio))
    else $error("result item differs from controller state");

  a_minus_act_once: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.phase == PH_MINUS_ACT) |=> state_r.phase == PH_MINUS_HELD)
    else $error("minus action not followed by hold");

  a_plus_act_once: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.phase == PH_PLUS_ACT) |=> state_r.phase == PH_PLUS_HELD)
    else $error("plus action not followed by hold");

endmodule

// ===== tb/tb_two_button_debounce_period_control.sv =====
// testbench for the debounce period controller: button tick streams checked against a predictor
`timescale 1ns / 1ps

module tb_two_button_debounce_period_control;
  import dbpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  two_button_debounce_period_control u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the controller
  logic [TICK_W-1:0]   lim_debounce = DEBOUNCE_RESET;
  logic [TICK_W-1:0]   lim_long_press = LONG_PRESS_RESET;
  logic [PERIOD_W-1:0] lim_period_max = PERIOD_MAX_RESET;
  phase_t              ctl_phase = PH_IDLE;
  logic [TICK_W-1:0]   ctl_elapsed = '0;
  logic [PERIOD_W-1:0] ctl_period = PERIOD_RESET;
  logic                ctl_audio = 1'b1;

  in_item_t  pending_ticks[$];
  out_item_t expected_results[$];
  out_item_t want;
  logic      in_fired = 1'b0;
  logic      idle_en = 1'b1;
  int        tx_gap = 0;
  int        rx_gap = 0;
  int        long_hold_left = 0;
  logic      long_hold_done = 1'b0;
  int        n_queued = 0;
  int        n_results = 0;
  int        n_errors = 0;
  int        n_writes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_two_button_debounce_period_control: FAIL");
    $finish;
  end

  function automatic out_item_t advance_controller(in_item_t tick);
    logic                minus_dn;
    logic                plus_dn;
    logic                clr;
    logic [TICK_W-1:0]   t;
    logic [PERIOD_W-1:0] top;
    out_item_t           r;
    minus_dn = !tick.minus_level;
    plus_dn  = !tick.plus_level;
    t        = ctl_elapsed;
    top      = (lim_period_max == '0) ? 4'd1 : lim_period_max;
    clr      = 1'b0;
    case (ctl_phase)
      PH_IDLE: begin
        if (minus_dn) begin
          clr = 1'b1;
          ctl_phase = PH_MINUS_DB;
        end else if (plus_dn) begin
          clr = 1'b1;
          ctl_phase = PH_PLUS_DB;
        end
      end
      PH_MINUS_DB: begin
        if (t >= lim_debounce) ctl_phase = minus_dn ? PH_MINUS_ACT : PH_IDLE;
      end
      PH_MINUS_ACT: begin
        ctl_period = (ctl_period >= top) ? 4'd1 : ctl_period + 4'd1;
        ctl_phase = PH_MINUS_HELD;
      end
      PH_MINUS_HELD: begin
        if (t >= lim_long_press) begin
          ctl_audio = 1'b0;
          clr = 1'b1;
        end
        if (!minus_dn) begin
          ctl_phase = PH_RELEASE_DB;
          clr = 1'b1;
        end
      end
      PH_RELEASE_DB: begin
        if (t >= lim_debounce) ctl_phase = PH_IDLE;
      end
      PH_PLUS_DB: begin
        if (t >= lim_debounce) ctl_phase = plus_dn ? PH_PLUS_ACT : PH_IDLE;
      end
      PH_PLUS_ACT: begin
        ctl_period = (ctl_period <= 4'd1 || ctl_period > top) ? top : ctl_period - 4'd1;
        ctl_phase = PH_PLUS_HELD;
      end
      default: begin
        if (t >= lim_long_press) begin
          ctl_audio = 1'b1;
          clr = 1'b1;
        end
        if (!plus_dn) begin
          ctl_phase = PH_RELEASE_DB;
          clr = 1'b1;
        end
      end
    endcase
    if (clr) ctl_elapsed = '0;
    else if (ctl_elapsed != TICK_TOP) ctl_elapsed = ctl_elapsed + 1'b1;
    r.period   = ctl_period;
    r.audio_on = ctl_audio;
    r.phase    = ctl_phase;
    return r;
  endfunction

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fired) begin
      // stalled item stays put
    end else if (tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      in_valid <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      tx_gap = $urandom_range(0, 6);
      in_valid <= 1'b0;
    end else if (pending_ticks.size() != 0) begin
      in_item <= pending_ticks.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left = long_hold_left - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && n_results >= 200 && pending_ticks.size() > 20) begin
      long_hold_done = 1'b1;
      long_hold_left = 60;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // prediction on accept, check on result
  always @(posedge clk) begin
    in_fired <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(advance_controller(in_item));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: period %0d audio %0b phase %0d",
                     out_item.period, out_item.audio_on, out_item.phase);
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (out_item.period !== want.period || out_item.audio_on !== want.audio_on ||
              out_item.phase !== want.phase) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d: expected period %0d audio %0b phase %0d, got %0d %0b %0d",
                       n_results, want.period, want.audio_on, want.phase,
                       out_item.period, out_item.audio_on, out_item.phase);
          end
        end
      end
    end
  end

  task automatic queue_ticks(logic minus_lvl, logic plus_lvl, int n);
    in_item_t tick;
    tick.minus_level = minus_lvl;
    tick.plus_level  = plus_lvl;
    repeat (n) begin
      pending_ticks.push_back(tick);
      n_queued++;
    end
  endtask

  task automatic queue_gesture();
    int   kind;
    int   hold;
    int   i;
    logic m;
    logic p;
    kind = $urandom_range(0, 9);
    m = !(kind < 4 || kind == 8);
    p = !((kind >= 4 && kind < 8) || kind == 8);
    repeat ($urandom_range(0, 3))
      queue_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
    case ($urandom_range(0, 3))
      0: hold = $urandom_range(1, lim_debounce + 1);
      1: hold = lim_debounce + 2 + $urandom_range(0, 3);
      default: hold = lim_debounce + 2 + lim_long_press * $urandom_range(1, 3) +
                      $urandom_range(0, 3);
    endcase
    for (i = 0; i < hold; i++) begin
      if (kind == 9) queue_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
      else if ($urandom_range(0, 31) == 0) queue_ticks(m, 1'($urandom_range(0, 1)), 1);
      else queue_ticks(m, p, 1);
    end
    repeat ($urandom_range(0, 2))
      queue_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
    queue_ticks(1'b1, 1'b1, lim_debounce + 2 + $urandom_range(0, 4));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE:   lim_debounce = val;
      CFG_LONG_PRESS: lim_long_press = val;
      CFG_PERIOD_MAX: lim_period_max = val[PERIOD_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_results != n_queued);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int                start;
    int                batch_start;
    int                phase_no;
    logic [3:0]        pm;
    logic [TICK_W-1:0] pm_word;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: fast thresholds, priority, wraps both ways, long press both ways
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'd1);
    write_reg(CFG_LONG_PRESS, 16'd2);
    write_reg(CFG_PERIOD_MAX, 16'd2);
    queue_ticks(1'b0, 1'b0, 5);
    queue_ticks(1'b1, 1'b1, 2);
    queue_ticks(1'b1, 1'b0, 5);
    queue_ticks(1'b1, 1'b1, 2);
    queue_ticks(1'b0, 1'b1, 1);
    queue_ticks(1'b1, 1'b1, 2);
    queue_ticks(1'b1, 1'b0, 3);
    queue_ticks(1'b1, 1'b1, 2);
    queue_ticks(1'b0, 1'b1, 3);
    queue_ticks(1'b1, 1'b1, 2);

    // random gestures, settings alternating high and low period limits
    phase_no = 0;
    start = n_queued;
    while (n_queued - start < 500) begin
      wait_drained();
      write_reg(CFG_DEBOUNCE, TICK_W'($urandom_range(0, 6)));
      write_reg(CFG_LONG_PRESS, TICK_W'($urandom_range(0, 20)));
      if (phase_no % 2 == 0) pm = 4'($urandom_range(8, 15));
      else if (phase_no == 1) pm = 4'd0;
      else pm = 4'($urandom_range(0, 4));
      pm_word = TICK_W'($urandom);
      pm_word[3:0] = pm;
      write_reg(CFG_PERIOD_MAX, pm_word);
      batch_start = n_queued;
      while (n_queued - batch_start < 100) queue_gesture();
      phase_no++;
    end

    // widest thresholds, no idling from here on
    wait_drained();
    idle_en = 1'b0;
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    write_reg(CFG_PERIOD_MAX, 16'hFFFF);
    queue_ticks(1'b1, 1'b1, 20);
    queue_ticks(1'b0, 1'b1, 60);
    queue_ticks(1'b1, 1'b1, 20);

    wait_drained();
    write_reg(CFG_DEBOUNCE, 16'd2);
    write_reg(CFG_LONG_PRESS, 16'd5);
    write_reg(CFG_PERIOD_MAX, 16'd7);
    start = n_queued;
    while (n_queued - start < 60) queue_gesture();

    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d button ticks over %0d random settings and %0d register writes",
             n_queued, phase_no, n_writes);
    $display("%0d result errors, %0d results outstanding", n_errors, expected_results.size());
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_two_button_debounce_period_control: PASS");
    end else begin
      $display("tb_two_button_debounce_period_control: FAIL");
    end
    $finish;
  end

endmodule
